// ===== sv/ebs_pkg.sv =====
// Shared constants and types for the bytecode block splitter.
// No dependencies; compile this file first.
`default_nettype none

package ebs_pkg;

  // Opcode values that the decoder treats specially.
  localparam logic [7:0] OP_STOP     = 8'h00;
  localparam logic [7:0] OP_ADD      = 8'h01;
  localparam logic [7:0] OP_SUB      = 8'h03;
  localparam logic [7:0] OP_JUMP     = 8'h56;
  localparam logic [7:0] OP_JUMPI    = 8'h57;
  localparam logic [7:0] OP_JUMPDEST = 8'h5B;
  localparam logic [7:0] OP_PUSH0    = 8'h5F;
  localparam logic [7:0] OP_PUSH1    = 8'h60;
  localparam logic [7:0] OP_PUSH32   = 8'h7F;
  localparam logic [7:0] OP_DUP1     = 8'h80;
  localparam logic [7:0] OP_SWAP16   = 8'h9F;
  localparam logic [7:0] OP_LOG4     = 8'hA4;
  localparam logic [7:0] OP_RETURN   = 8'hF3;
  localparam logic [7:0] OP_REVERT   = 8'hFD;
  localparam logic [7:0] OP_INVALID  = 8'hFE;
  localparam logic [7:0] OP_SELFDEST = 8'hFF;

  // Result kind codes.
  localparam logic [2:0] KIND_OTHER    = 3'd0;
  localparam logic [2:0] KIND_PUSH     = 3'd1;
  localparam logic [2:0] KIND_ADD      = 3'd2;
  localparam logic [2:0] KIND_SUB      = 3'd3;
  localparam logic [2:0] KIND_JUMP     = 3'd4;
  localparam logic [2:0] KIND_JUMPDEST = 3'd5;
  localparam logic [2:0] KIND_RETURN   = 3'd6;
  localparam logic [2:0] KIND_REVERT   = 3'd7;

  // Decoded view of one opcode byte.
  typedef struct packed {
    logic       mapped;
    logic       is_push;
    logic       closes;
    logic [2:0] kind;
    logic [5:0] push_len;
  } dec_t;

endpackage

`default_nettype wire

// ===== sv/ebs_if.sv =====
// Valid/ready channel interfaces for the bytecode block splitter.
// Standalone; used by the top level and its environment.
`default_nettype none

interface ebs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       final_byte;

  modport source (output valid, output code_byte, output final_byte, input ready);
  modport sink   (input valid, input code_byte, input final_byte, output ready);
endinterface

interface ebs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] byte_pc;
  logic        is_immediate;
  logic [2:0]  kind;
  logic [5:0]  push_length;
  logic [4:0]  operand_index;
  logic        block_end;
  logic [15:0] block_start_pc;
  logic        bad_opcode;
  logic        failed;
  logic        last;
  logic        parse_ok;

  modport source (
    output valid, input ready,
    output byte_pc, output is_immediate, output kind, output push_length,
    output operand_index, output block_end, output block_start_pc,
    output bad_opcode, output failed, output last, output parse_ok
  );
  modport sink (
    input valid, output ready,
    input byte_pc, input is_immediate, input kind, input push_length,
    input operand_index, input block_end, input block_start_pc,
    input bad_opcode, input failed, input last, input parse_ok
  );
endinterface

`default_nettype wire

// ===== sv/ebs_decode.sv =====
// Opcode table: mapped check, kind, push length and block-closing flag.
// Depends on ebs_pkg.
`default_nettype none

module ebs_decode (
  input  wire logic [7:0] code_byte,
  output ebs_pkg::dec_t   dec
);
  import ebs_pkg::*;

  logic mapped;
  logic is_push;
  logic [2:0] kind;

  always_comb begin
    mapped = 1'b0;
    if (code_byte <= 8'h0B) mapped = 1'b1;
    if (code_byte >= 8'h10 && code_byte <= 8'h1D) mapped = 1'b1;
    if (code_byte == 8'h20) mapped = 1'b1;
    if (code_byte >= 8'h30 && code_byte <= 8'h48) mapped = 1'b1;
    if (code_byte >= 8'h50 && code_byte <= OP_JUMPDEST) mapped = 1'b1;
    if (code_byte >= OP_PUSH1 && code_byte <= OP_LOG4) mapped = 1'b1;
    if (code_byte >= 8'hF0 && code_byte <= 8'hF5) mapped = 1'b1;
    if (code_byte == 8'hFA || code_byte >= OP_REVERT) mapped = 1'b1;
  end

  assign is_push = (code_byte >= OP_PUSH1) && (code_byte <= OP_PUSH32);

  always_comb begin
    if (is_push) begin
      kind = KIND_PUSH;
    end else begin
      unique case (code_byte)
        OP_ADD:            kind = KIND_ADD;
        OP_SUB:            kind = KIND_SUB;
        OP_JUMP, OP_JUMPI: kind = KIND_JUMP;
        OP_JUMPDEST:       kind = KIND_JUMPDEST;
        OP_RETURN:         kind = KIND_RETURN;
        OP_REVERT:         kind = KIND_REVERT;
        default:           kind = KIND_OTHER;
      endcase
    end
  end

  always_comb begin
    dec.mapped  = mapped;
    dec.is_push = is_push;
    dec.kind    = kind;
    // PUSH1..PUSH32 sit at 0x60..0x7F, so the low five bits plus one give the length.
    dec.push_len = is_push ? ({1'b0, code_byte[4:0]} + 6'd1) : 6'd0;
    dec.closes = (code_byte == OP_STOP) || (code_byte == OP_JUMP) ||
                 (code_byte == OP_JUMPI) || (code_byte == OP_RETURN) ||
                 (code_byte == OP_REVERT) || (code_byte == OP_INVALID) ||
                 (code_byte == OP_SELFDEST);
  end

endmodule

`default_nettype wire

// ===== sv/evm_bytecode_block_splitter.sv =====
// Top level of the bytecode block splitter: per-byte state and result register.
// Depends on ebs_pkg, ebs_if (ebs_in_if, ebs_out_if) and ebs_decode.
//
//   Channel | Direction | Carries
//   in_ch   | sink      | code_byte, final_byte
//   out_ch  | source    | one decoded result per input byte
//
// Each accepted item is decoded in the cycle it arrives and its result appears
// in the output register on the next cycle; one item per cycle is sustained
// unless out_ch stalls. The output register is the only stage, so in_ch.ready
// is high whenever that register is empty or is being emptied in the same cycle.
// Synchronous reset clears the program counter, block start, immediate
// tracking, the failure flag and the output valid.
`default_nettype none

module evm_bytecode_block_splitter #(
  parameter int PC_BITS = 16
) (
  input wire logic  clk,
  input wire logic  rst_n,
  ebs_in_if.sink    in_ch,
  ebs_out_if.source out_ch
);
  import ebs_pkg::*;

  localparam int EXT_W = (PC_BITS > 16) ? PC_BITS : 16;

  // Per-program state.
  logic [PC_BITS-1:0] next_pc_r, next_pc_nxt;
  logic [PC_BITS-1:0] blk_start_r, blk_start_nxt;
  logic [5:0]         imm_left_r, imm_left_nxt;
  logic [4:0]         imm_pos_r, imm_pos_nxt;
  logic               fail_r, fail_nxt;

  // Result register.
  logic        out_valid_r;
  logic [15:0] byte_pc_r, byte_pc_nxt;
  logic        is_imm_r, is_imm_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [5:0]  plen_r, plen_nxt;
  logic [4:0]  opidx_r, opidx_nxt;
  logic        blk_end_r, blk_end_nxt;
  logic [15:0] blk_pc_r, blk_pc_nxt;
  logic        bad_r, bad_nxt;
  logic        failed_r;
  logic        last_r;
  logic        parse_ok_r, parse_ok_nxt;

  dec_t               dec;
  logic               accept;
  logic [PC_BITS-1:0] pc_inc;
  logic [EXT_W-1:0]   pc_ext;
  logic [EXT_W-1:0]   blk_ext;

  ebs_decode u_dec (
    .code_byte (in_ch.code_byte),
    .dec       (dec)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pc_inc      = next_pc_r + PC_BITS'(1);
  assign pc_ext      = EXT_W'(next_pc_r);
  assign blk_ext     = EXT_W'(blk_start_r);

  always_comb begin
    imm_left_nxt = imm_left_r;
    imm_pos_nxt  = imm_pos_r;
    fail_nxt     = fail_r;
    is_imm_nxt   = 1'b0;
    kind_nxt     = KIND_OTHER;
    plen_nxt     = 6'd0;
    opidx_nxt    = 5'd0;
    bad_nxt      = 1'b0;
    blk_end_nxt  = in_ch.final_byte;

    if (imm_left_r != 6'd0) begin
      // Immediate bytes are passed through without looking them up.
      is_imm_nxt   = 1'b1;
      opidx_nxt    = imm_pos_r;
      imm_left_nxt = imm_left_r - 6'd1;
      imm_pos_nxt  = imm_pos_r + 5'd1;
    end else if (!dec.mapped) begin
      bad_nxt  = 1'b1;
      fail_nxt = 1'b1;
    end else begin
      kind_nxt = dec.kind;
      plen_nxt = dec.push_len;
      if (dec.is_push) begin
        imm_left_nxt = dec.push_len;
        imm_pos_nxt  = 5'd0;
      end
      if (dec.closes) blk_end_nxt = 1'b1;
    end

    byte_pc_nxt  = pc_ext[15:0];
    blk_pc_nxt   = blk_ext[15:0];
    parse_ok_nxt = in_ch.final_byte && !fail_nxt;

    next_pc_nxt   = pc_inc;
    blk_start_nxt = blk_end_nxt ? pc_inc : blk_start_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_pc_r   <= '0;
      blk_start_r <= '0;
      imm_left_r  <= '0;
      imm_pos_r   <= '0;
      fail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        if (in_ch.final_byte) begin
          // The program ends here; any pending immediates are dropped.
          next_pc_r   <= '0;
          blk_start_r <= '0;
          imm_left_r  <= '0;
          imm_pos_r   <= '0;
          fail_r      <= 1'b0;
        end else begin
          next_pc_r   <= next_pc_nxt;
          blk_start_r <= blk_start_nxt;
          imm_left_r  <= imm_left_nxt;
          imm_pos_r   <= imm_pos_nxt;
          fail_r      <= fail_nxt;
        end
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_pc_r  <= byte_pc_nxt;
      is_imm_r   <= is_imm_nxt;
      kind_r     <= kind_nxt;
      plen_r     <= plen_nxt;
      opidx_r    <= opidx_nxt;
      blk_end_r  <= blk_end_nxt;
      blk_pc_r   <= blk_pc_nxt;
      bad_r      <= bad_nxt;
      failed_r   <= fail_nxt;
      last_r     <= in_ch.final_byte;
      parse_ok_r <= parse_ok_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.byte_pc        = byte_pc_r;
  assign out_ch.is_immediate   = is_imm_r;
  assign out_ch.kind           = kind_r;
  assign out_ch.push_length    = plen_r;
  assign out_ch.operand_index  = opidx_r;
  assign out_ch.block_end      = blk_end_r;
  assign out_ch.block_start_pc = blk_pc_r;
  assign out_ch.bad_opcode     = bad_r;
  assign out_ch.failed         = failed_r;
  assign out_ch.last           = last_r;
  assign out_ch.parse_ok       = parse_ok_r;

endmodule

`default_nettype wire

// ===== verif/evm_bytecode_block_splitter_test.sv =====
// Self-checking testbench for evm_bytecode_block_splitter: streams bytecode programs
// and compares every decoded byte with a local predictor. Depends on ebs_pkg,
// ebs_if and the splitter RTL.
`timescale 1ns / 100ps

module evm_bytecode_block_splitter_test;
  import ebs_pkg::*;

  // Range bounds of the opcode map that the package does not name.
  localparam logic [7:0] OP_SIGNEXTEND = 8'h0B;
  localparam logic [7:0] OP_LT         = 8'h10;
  localparam logic [7:0] OP_SAR        = 8'h1D;
  localparam logic [7:0] OP_KECCAK     = 8'h20;
  localparam logic [7:0] OP_ADDRESS    = 8'h30;
  localparam logic [7:0] OP_BASEFEE    = 8'h48;
  localparam logic [7:0] OP_POP        = 8'h50;
  localparam logic [7:0] OP_CREATE     = 8'hF0;
  localparam logic [7:0] OP_CREATE2    = 8'hF5;
  localparam logic [7:0] OP_STATICCALL = 8'hFA;
  // Unmapped bytes used in the directed programs.
  localparam logic [7:0] OP_HOLE_FB    = 8'hFB;
  localparam logic [7:0] OP_HOLE_A5    = 8'hA5;

  localparam int unsigned CYCLE_LIMIT   = 5_000_000;
  localparam int unsigned QUIET_ITEMS   = 150;
  localparam int unsigned RANDOM_ITEMS  = 900;

  typedef struct packed {
    logic [7:0] code;
    logic       fin;
  } code_item_t;

  typedef struct packed {
    logic [15:0] byte_pc;
    logic        is_immediate;
    logic [2:0]  kind;
    logic [5:0]  push_length;
    logic [4:0]  operand_index;
    logic        block_end;
    logic [15:0] block_start_pc;
    logic        bad_opcode;
    logic        failed;
    logic        last;
    logic        parse_ok;
  } decoded_byte_t;

  logic clk;
  logic rst_n;

  ebs_in_if  in_ch ();
  ebs_out_if out_ch ();

  evm_bytecode_block_splitter DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  code_item_t    pending_bytes[$];
  decoded_byte_t expected_decodes[$];
  int unsigned   error_count;
  int unsigned   cycle_count;

  // Predictor state, mirrors the decoder's registers.
  logic [15:0] pc_next = '0;
  logic [5:0]  imm_left = '0;
  logic [4:0]  imm_pos = '0;
  logic [15:0] blk_start = '0;
  logic        fail_seen = 1'b0;

  always begin
    #4 clk = 1'b0;
    #4 clk = 1'b1;
  end

  function automatic logic opcode_mapped(logic [7:0] op);
    return (op <= OP_SIGNEXTEND) || (op >= OP_LT && op <= OP_SAR) || (op == OP_KECCAK) ||
           (op >= OP_ADDRESS && op <= OP_BASEFEE) || (op >= OP_POP && op <= OP_JUMPDEST) ||
           (op >= OP_PUSH1 && op <= OP_LOG4) || (op >= OP_CREATE && op <= OP_CREATE2) ||
           (op == OP_STATICCALL) || (op >= OP_REVERT);
  endfunction

  function automatic logic quiet_phase();
    return pending_bytes.size() < QUIET_ITEMS;
  endfunction

  task automatic predict_byte(input code_item_t it);
    decoded_byte_t r;
    logic          closes;
    r = '0;
    r.byte_pc = pc_next;
    r.block_start_pc = blk_start;
    r.last = it.fin;
    closes = it.fin;
    if (imm_left != 0) begin
      // Immediate bytes bypass the opcode map entirely.
      r.is_immediate = 1'b1;
      r.operand_index = imm_pos;
      imm_left = imm_left - 6'd1;
      imm_pos = imm_pos + 5'd1;
    end else if (!opcode_mapped(it.code)) begin
      r.bad_opcode = 1'b1;
      fail_seen = 1'b1;
    end else begin
      if (it.code >= OP_PUSH1 && it.code <= OP_PUSH32) begin
        r.kind = KIND_PUSH;
        r.push_length = 6'(it.code - OP_PUSH0);
        imm_left = r.push_length;
        imm_pos = '0;
      end else begin
        case (it.code)
          OP_ADD: r.kind = KIND_ADD;
          OP_SUB: r.kind = KIND_SUB;
          OP_JUMP, OP_JUMPI: r.kind = KIND_JUMP;
          OP_JUMPDEST: r.kind = KIND_JUMPDEST;
          OP_RETURN: r.kind = KIND_RETURN;
          OP_REVERT: r.kind = KIND_REVERT;
          default: r.kind = KIND_OTHER;
        endcase
      end
      case (it.code)
        OP_STOP, OP_JUMP, OP_JUMPI, OP_RETURN, OP_REVERT, OP_INVALID, OP_SELFDEST: begin
          closes = 1'b1;
        end
        default: ;
      endcase
    end
    r.block_end = closes;
    r.failed = fail_seen;
    r.parse_ok = it.fin && !fail_seen;
    if (it.fin) begin
      pc_next = '0;
      imm_left = '0;
      imm_pos = '0;
      blk_start = '0;
      fail_seen = 1'b0;
    end else begin
      pc_next = pc_next + 16'd1;
      if (closes) blk_start = pc_next;
    end
    expected_decodes.insert(expected_decodes.size(), r);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  task automatic queue_byte(input logic [7:0] code, input logic fin);
    code_item_t it;
    it.code = code;
    it.fin = fin;
    pending_bytes.insert(pending_bytes.size(), it);
  endtask

  function automatic logic [7:0] random_opcode();
    int unsigned r;
    logic [7:0]  op;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      do op = 8'($urandom_range(0, 255)); while (opcode_mapped(op));
    end else if (r < 30) begin
      // Mostly short pushes so that programs do not drown in immediates.
      if ($urandom_range(0, 1) == 0) op = OP_PUSH1 + 8'($urandom_range(0, 3));
      else op = OP_PUSH1 + 8'($urandom_range(0, 31));
    end else if (r < 45) begin
      case ($urandom_range(0, 9))
        0: op = OP_STOP;
        1: op = OP_ADD;
        2: op = OP_SUB;
        3: op = OP_JUMP;
        4: op = OP_JUMPI;
        5: op = OP_JUMPDEST;
        6: op = OP_RETURN;
        7: op = OP_REVERT;
        8: op = OP_INVALID;
        default: op = OP_SELFDEST;
      endcase
    end else begin
      do op = 8'($urandom_range(0, 255)); while (!opcode_mapped(op));
    end
    return op;
  endfunction

  // A program of len bytes; a push near the end is cut short by the final byte.
  task automatic add_program(input int unsigned len);
    int unsigned n;
    int unsigned k;
    int unsigned plen;
    logic [7:0]  op;
    n = 0;
    while (n < len) begin
      op = random_opcode();
      queue_byte(op, n == len - 1);
      n++;
      if (op >= OP_PUSH1 && op <= OP_PUSH32) begin
        plen = 32'(op - OP_PUSH0);
        for (k = 0; k < plen && n < len; k++) begin
          queue_byte(8'($urandom_range(0, 255)), n == len - 1);
          n++;
        end
      end
    end
  endtask

  // Driver: holds an item until it is taken, idles in random bursts otherwise.
  int unsigned in_gap;
  logic        in_storm;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.code_byte <= '0;
      in_ch.final_byte <= 1'b0;
      in_gap = 0;
      in_storm = 1'b1;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_byte(pending_bytes.pop_front());
      end
      if ($urandom_range(0, 99) == 0) in_storm = !in_storm;
      if (in_ch.valid && !in_ch.ready) begin
        // Item still waiting; keep it on the bus.
      end else if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_bytes.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (!quiet_phase() && in_storm && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(1, 8) - 1;
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.code_byte <= pending_bytes[0].code;
        in_ch.final_byte <= pending_bytes[0].fin;
      end
    end
  end

  // Monitor: checks each accepted result and stalls the output at random.
  int unsigned   out_gap;
  logic          out_storm;
  decoded_byte_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
      out_storm = 1'b1;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_decodes.size() == 0) begin
          $error("result at pc %0d arrived with no item outstanding", out_ch.byte_pc);
          error_count++;
        end else begin
          want = expected_decodes.pop_front();
          check_field("byte_pc", 32'(want.byte_pc), 32'(out_ch.byte_pc));
          check_field("is_immediate", 32'(want.is_immediate), 32'(out_ch.is_immediate));
          check_field("kind", 32'(want.kind), 32'(out_ch.kind));
          check_field("push_length", 32'(want.push_length), 32'(out_ch.push_length));
          check_field("operand_index", 32'(want.operand_index), 32'(out_ch.operand_index));
          check_field("block_end", 32'(want.block_end), 32'(out_ch.block_end));
          check_field("block_start_pc", 32'(want.block_start_pc),
                      32'(out_ch.block_start_pc));
          check_field("bad_opcode", 32'(want.bad_opcode), 32'(out_ch.bad_opcode));
          check_field("failed", 32'(want.failed), 32'(out_ch.failed));
          check_field("last", 32'(want.last), 32'(out_ch.last));
          check_field("parse_ok", 32'(want.parse_ok), 32'(out_ch.parse_ok));
        end
      end
      if ($urandom_range(0, 99) == 0) out_storm = !out_storm;
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else if (!quiet_phase() && out_storm && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(1, 8) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned random_total;
    int unsigned len;
    rst_n = 1'b0;

    // Clean program touching every kind and every block closer but STOP.
    queue_byte(OP_PUSH1, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(OP_ADD, 1'b0);
    queue_byte(OP_SUB, 1'b0);
    queue_byte(OP_JUMPDEST, 1'b0);
    queue_byte(OP_JUMP, 1'b0);
    queue_byte(OP_JUMPI, 1'b0);
    queue_byte(OP_RETURN, 1'b0);
    queue_byte(OP_REVERT, 1'b0);
    queue_byte(OP_INVALID, 1'b0);
    queue_byte(OP_SELFDEST, 1'b1);
    // Unmapped opcodes, including PUSH0; decoding must carry on after them.
    queue_byte(OP_PUSH0, 1'b0);
    queue_byte(OP_HOLE_FB, 1'b0);
    queue_byte(OP_STOP, 1'b0);
    queue_byte(OP_DUP1, 1'b0);
    queue_byte(OP_SWAP16, 1'b0);
    queue_byte(OP_LOG4, 1'b0);
    queue_byte(OP_HOLE_A5, 1'b1);
    // PUSH32 cut short by the final byte, whose value looks like an opcode.
    queue_byte(OP_PUSH32, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(OP_PUSH0, 1'b1);
    // One-byte program.
    queue_byte(OP_STOP, 1'b1);

    random_total = 0;
    while (random_total < RANDOM_ITEMS / 2) begin
      len = $urandom_range(1, 40);
      add_program(len);
      random_total += len;
    end
    while (random_total < RANDOM_ITEMS) begin
      len = $urandom_range(1, 40);
      add_program(len);
      random_total += len;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || expected_decodes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ebs_pkg.sv
sv/ebs_if.sv
sv/ebs_decode.sv
sv/evm_bytecode_block_splitter.sv
verif/evm_bytecode_block_splitter_test.sv
